/* rtl/brm_pkg.sv */
// Byte register machine package: opcode and status codes.
// No dependencies; used by byte_register_machine_core_top.
package brm_pkg;

    typedef enum logic [7:0] {
        OP_INC  = 8'h01,
        OP_DEC  = 8'h02,
        OP_MOV  = 8'h03,
        OP_MOVC = 8'h04,
        OP_LSL  = 8'h05,
        OP_LSR  = 8'h06,
        OP_JMP  = 8'h07,
        OP_JZ   = 8'h08,
        OP_JNZ  = 8'h09,
        OP_JFE  = 8'h0A,
        OP_RET  = 8'h0B,
        OP_ADD  = 8'h0C,
        OP_SUB  = 8'h0D,
        OP_XOR  = 8'h0E,
        OP_OR   = 8'h0F,
        OP_IN   = 8'h10,
        OP_OUT  = 8'h11
    } t_opcode;

    typedef enum logic [1:0] {
        ST_RUN     = 2'd0,
        ST_HALT    = 2'd1,
        ST_ILLEGAL = 2'd2
    } t_status;

    localparam logic [7:0] PC_STEP = 8'd2;

endpackage

/* rtl/byte_register_machine_core_top.sv */
// Byte register machine core: executes one two-byte instruction per transaction.
// Depends on brm_pkg (opcodes, status codes).
//
// Pipeline: the register file is read into the execute stage when the input
//   transaction is accepted; execute writes the output register when it retires.
// Throughput: one instruction per cycle unless i_ready stalls; the register file's
//   synchronous read overlaps the previous instruction's execute and write-back.
// Reset: synchronous, active low. Clears counter, flags, halt mark, pipeline
//   valids and the per-register valid bits; registers never written read as zero,
//   so no clearing pass is needed.
module byte_register_machine_core_top #(
    parameter int REG_COUNT = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_operation,
    input  logic [7:0] i_operand,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_end,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_next_fetch,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_zero_now,
    output logic       o_end_now
);

    localparam int AW = $clog2(REG_COUNT);

    // Register file: one write port, two synchronous read ports (x and y).
    logic [7:0]           mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_written;   // entry written since reset

    // Architectural control state
    logic [7:0] r_pc;
    logic       r_zero;
    logic       r_end;
    logic       r_halt;

    // Execute stage (item whose operands were read when it was accepted)
    logic       r_ex_valid;
    logic [7:0] r_ex_op;
    logic [7:0] r_ex_arg;
    logic [7:0] r_ex_data;
    logic       r_ex_at_end;

    // Read data and bypass captured at the read edge
    logic [7:0] r_rd_x;
    logic [7:0] r_rd_y;
    logic       r_vld_x;
    logic       r_vld_y;
    logic       r_fwd_x;
    logic       r_fwd_y;
    logic [7:0] r_fwd_data;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_next_fetch;
    logic       r_emit;
    logic [7:0] r_emitted;
    logic [1:0] r_status;
    logic       r_zero_out;
    logic       r_end_out;

    logic          in_fire;
    logic          ex_fire;
    logic [AW-1:0] in_x;
    logic [AW-1:0] in_y;
    logic [AW-1:0] ex_x;
    logic [7:0]    opa;
    logic [7:0]    opb;
    logic [7:0]    advance;
    logic [7:0]    jumped;

    // Execute results
    logic [7:0]    n_pc;
    logic          n_zero;
    logic          n_end;
    logic          n_halt;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          emit;
    logic [7:0]    emitted;
    logic [1:0]    status;

    // Handshake: execute retires when the output register is free or draining.
    assign ex_fire = r_ex_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_ex_valid || ex_fire;
    assign in_fire = i_valid && o_ready;

    assign in_x = i_operand[AW-1:0];
    assign in_y = i_operand[4 +: AW];
    assign ex_x = r_ex_arg[AW-1:0];

    // Operand select: a write retiring at the read edge wins over stale memory data;
    // never-written entries read as zero.
    assign opa = r_fwd_x ? r_fwd_data : (r_vld_x ? r_rd_x : 8'd0);
    assign opb = r_fwd_y ? r_fwd_data : (r_vld_y ? r_rd_y : 8'd0);

    assign advance = r_pc + brm_pkg::PC_STEP;
    assign jumped  = r_pc + r_ex_arg;

    always_comb begin
        n_pc    = r_pc;
        n_zero  = r_zero;
        n_end   = r_end;
        n_halt  = r_halt;
        wr_en   = 1'b0;
        wr_addr = ex_x;
        wr_data = opa;
        emit    = 1'b0;
        emitted = 8'd0;
        status  = brm_pkg::ST_RUN;
        if (r_halt) begin
            status = brm_pkg::ST_HALT;
        end else begin
            case (r_ex_op)
                brm_pkg::OP_INC: begin
                    wr_en = 1'b1; wr_data = opa + 8'd1;
                end
                brm_pkg::OP_DEC: begin
                    wr_en = 1'b1; wr_data = opa - 8'd1;
                end
                brm_pkg::OP_MOV: begin
                    wr_en = 1'b1; wr_data = opb;
                end
                brm_pkg::OP_MOVC: begin
                    wr_en = 1'b1; wr_addr = '0; wr_data = r_ex_arg;
                end
                brm_pkg::OP_LSL: begin
                    wr_en = 1'b1; wr_data = {opa[6:0], 1'b0};
                end
                brm_pkg::OP_LSR: begin
                    wr_en = 1'b1; wr_data = {1'b0, opa[7:1]};
                end
                brm_pkg::OP_ADD: begin
                    wr_en = 1'b1; wr_data = opa + opb;
                end
                brm_pkg::OP_SUB: begin
                    wr_en = 1'b1; wr_data = opa - opb;
                end
                brm_pkg::OP_XOR: begin
                    wr_en = 1'b1; wr_data = opa ^ opb;
                end
                brm_pkg::OP_OR: begin
                    wr_en = 1'b1; wr_data = opa | opb;
                end
                brm_pkg::OP_JMP: begin
                    n_pc = jumped; n_zero = 1'b0; n_end = 1'b0;
                end
                brm_pkg::OP_JZ: begin
                    n_pc = r_zero ? jumped : advance; n_zero = 1'b0; n_end = 1'b0;
                end
                brm_pkg::OP_JNZ: begin
                    n_pc = r_zero ? advance : jumped; n_zero = 1'b0; n_end = 1'b0;
                end
                brm_pkg::OP_JFE: begin
                    n_pc = r_end ? jumped : advance; n_zero = 1'b0; n_end = 1'b0;
                end
                brm_pkg::OP_RET: begin
                    n_halt = 1'b1;
                    status = brm_pkg::ST_HALT;
                end
                brm_pkg::OP_IN: begin
                    n_pc = advance;
                    if (r_ex_at_end) begin
                        n_end = 1'b1;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = r_ex_data;
                        n_end   = 1'b0;
                    end
                end
                brm_pkg::OP_OUT: begin
                    n_pc    = advance;
                    n_zero  = 1'b0;
                    emit    = 1'b1;
                    emitted = opa;
                end
                default: begin
                    status = brm_pkg::ST_ILLEGAL;
                end
            endcase
            // ALU group: zero from the new value, end cleared, counter advances
            if (wr_en && (r_ex_op != brm_pkg::OP_IN)) begin
                n_pc   = advance;
                n_zero = (wr_data == 8'd0);
                n_end  = 1'b0;
            end
        end
    end

    // Register file write port
    always_ff @(posedge i_clk) begin
        if (ex_fire && wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register file read ports; held while the execute stage stalls.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_x <= mem[in_x];
            r_rd_y <= mem[in_y];
        end
    end

    // Bypass capture and pipeline payload (no reset needed)
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_vld_x     <= r_written[in_x];
            r_vld_y     <= r_written[in_y];
            r_fwd_x     <= ex_fire && wr_en && (wr_addr == in_x);
            r_fwd_y     <= ex_fire && wr_en && (wr_addr == in_y);
            r_fwd_data  <= wr_data;
            r_ex_op     <= i_operation;
            r_ex_arg    <= i_operand;
            r_ex_data   <= i_in_byte;
            r_ex_at_end <= i_in_end;
        end
        if (ex_fire) begin
            r_next_fetch <= n_pc;
            r_emit       <= emit;
            r_emitted    <= emitted;
            r_status     <= status;
            r_zero_out   <= n_zero;
            r_end_out    <= n_end;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written   <= '0;
            r_pc        <= 8'd0;
            r_zero      <= 1'b0;
            r_end       <= 1'b0;
            r_halt      <= 1'b0;
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_ex_valid <= 1'b1;
            end else if (ex_fire) begin
                r_ex_valid <= 1'b0;
            end
            if (ex_fire) begin
                r_pc        <= n_pc;
                r_zero      <= n_zero;
                r_end       <= n_end;
                r_halt      <= n_halt;
                r_out_valid <= 1'b1;
                if (wr_en) begin
                    r_written[wr_addr] <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_next_fetch = r_next_fetch;
    assign o_out_valid  = r_emit;
    assign o_out_byte   = r_emitted;
    assign o_status     = r_status;
    assign o_zero_now   = r_zero_out;
    assign o_end_now    = r_end_out;

endmodule
